FILE: rtl/stack_with_search_and_middle_core_defines.svh
// Assertion macros used by the port-level checker file.
`ifndef STACK_WITH_SEARCH_AND_MIDDLE_CORE_DEFINES_SVH
`define STACK_WITH_SEARCH_AND_MIDDLE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and masked during reset.
`define SWSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and masked during reset.
`define SWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/swsm_pkg.sv
// Shared constants and codes for the stack with search and middle lookup.
package swsm_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int IW      = $clog2(DEPTH + 2);

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_MIDDLE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

FILE: rtl/stack_with_search_and_middle_core.sv
// Top level: bounded LIFO stack with push, pop, key search and middle lookup.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_ready, req_type,         | into block
//          | data_value                            |
//  out     | out_valid, out_ready, status,         | out of block
//          | entry_value, position, last           |
//
// Push, pop and middle: result registered from S_REPLY once the output is free; the
// next item is not taken until that result is loaded.
// Search: the single read port reads one entry per cycle from the top unless a match
// waits on a stalled output; compare runs in the next cycle; final result in S_FINISH.
// Output stalls hold the sequencer only when a result has to be loaded.
// Reset clears the entry count; the storage itself is not cleared.
// in_ready is high only while the sequencer is idle.
module stack_with_search_and_middle_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         req_type,
    input  logic signed [swsm_pkg::DATA_W-1:0] data_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [swsm_pkg::DATA_W-1:0] entry_value,
    output logic [swsm_pkg::POS_W-1:0]         position,
    output logic                               last
);
    import swsm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REPLY,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [1:0]               rep_status_reg, rep_status_next;
    logic                     rep_mem_reg, rep_mem_next;
    logic [CW-1:0]            rep_pos_reg, rep_pos_next;
    logic [IW-1:0]            issue_pos_reg, issue_pos_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]            cmp_pos_reg, cmp_pos_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [CW-1:0]            pend_pos_reg, pend_pos_next;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] entry_value_reg, entry_value_next;
    logic [POS_W-1:0]         position_reg, position_next;
    logic                     last_reg, last_next;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    logic                     out_free;
    logic                     hit;
    logic                     stall;
    logic [CW-1:0]            mid_pos;

    swsm_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign hit      = cmp_valid_reg && (mem_rdata == key_reg);
    assign stall    = hit && pend_valid_reg && !out_free;
    assign mid_pos  = (count_reg >> 1) + CW'(1);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        rep_status_next  = rep_status_reg;
        rep_mem_next     = rep_mem_reg;
        rep_pos_next     = rep_pos_reg;
        issue_pos_next   = issue_pos_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_pos_next     = cmp_pos_reg;
        pend_valid_next  = pend_valid_reg;
        pend_pos_next    = pend_pos_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        entry_value_next = entry_value_reg;
        position_next    = position_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        mem_waddr        = AW'(count_reg);
        mem_re           = 1'b0;
        mem_raddr        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = data_value;
                    rep_status_next = ST_OK;
                    rep_mem_next    = 1'b0;
                    rep_pos_next    = '0;
                    state_next      = S_REPLY;
                    unique case (req_type)
                        REQ_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                rep_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                rep_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = AW'(count_reg - CW'(1));
                                count_next   = count_reg - CW'(1);
                                rep_mem_next = 1'b1;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            issue_pos_next  = IW'(1);
                            cmp_valid_next  = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        REQ_MIDDLE:
                        begin
                            if (count_reg == '0)
                            begin
                                rep_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = AW'(count_reg - mid_pos);
                                rep_mem_next = 1'b1;
                                rep_pos_next = mid_pos;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = rep_status_reg;
                    entry_value_next = rep_mem_reg ? mem_rdata : '0;
                    position_next    = POS_W'(rep_pos_reg);
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    if (issue_pos_reg <= IW'(count_reg))
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = AW'(IW'(count_reg) - issue_pos_reg);
                        cmp_valid_next = 1'b1;
                        cmp_pos_next   = CW'(issue_pos_reg);
                        issue_pos_next = issue_pos_reg + IW'(1);
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                        if (!cmp_valid_reg)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next   = 1'b1;
                            status_next      = ST_OK;
                            entry_value_next = key_reg;
                            position_next    = POS_W'(pend_pos_reg);
                            last_next        = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_pos_next   = cmp_pos_reg;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (pend_valid_reg)
                    begin
                        status_next      = ST_OK;
                        entry_value_next = key_reg;
                        position_next    = POS_W'(pend_pos_reg);
                    end
                    else
                    begin
                        status_next      = ST_NOTFOUND;
                        entry_value_next = '0;
                        position_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            key_reg         <= '0;
            rep_status_reg  <= ST_OK;
            rep_mem_reg     <= 1'b0;
            rep_pos_reg     <= '0;
            issue_pos_reg   <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_pos_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            pend_pos_reg    <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            entry_value_reg <= '0;
            position_reg    <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            key_reg         <= key_next;
            rep_status_reg  <= rep_status_next;
            rep_mem_reg     <= rep_mem_next;
            rep_pos_reg     <= rep_pos_next;
            issue_pos_reg   <= issue_pos_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_pos_reg     <= cmp_pos_next;
            pend_valid_reg  <= pend_valid_next;
            pend_pos_reg    <= pend_pos_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            entry_value_reg <= entry_value_next;
            position_reg    <= position_next;
            last_reg        <= last_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_value = entry_value_reg;
    assign position    = position_reg;
    assign last        = last_reg;

endmodule

FILE: rtl/swsm_mem.sv
// Stack storage: one write port and one read port with registered read data.
module swsm_mem (
    input  logic                               clk,
    input  logic                               we,
    input  logic [swsm_pkg::AW-1:0]            waddr,
    input  logic signed [swsm_pkg::DATA_W-1:0] wdata,
    input  logic                               re,
    input  logic [swsm_pkg::AW-1:0]            raddr,
    output logic signed [swsm_pkg::DATA_W-1:0] rdata
);
    import swsm_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/swsm_checker.sv
// Port-level checker for the stack core, bound to the top level.
`include "stack_with_search_and_middle_core_defines.svh"

module swsm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [1:0]                         req_type,
    input logic signed [swsm_pkg::DATA_W-1:0] data_value,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [1:0]                         status,
    input logic signed [swsm_pkg::DATA_W-1:0] entry_value,
    input logic [swsm_pkg::POS_W-1:0]         position,
    input logic                               last
);
    import swsm_pkg::*;

    `SWSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(entry_value) && $stable(last), "result dropped or changed while stalled")
    `SWSM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "new item taken while previous item still in work")
    `SWSM_ASSERT_NOW(a_error_fields, out_valid && (status == ST_FULL || status == ST_EMPTY || status == ST_NOTFOUND), last && position == '0 && entry_value == '0, "error result carries data or is not last")
    `SWSM_ASSERT_NOW(a_partial_search, out_valid && !last, status == ST_OK && position != '0, "non-final result is not a search match")

endmodule

bind stack_with_search_and_middle_core swsm_checker u_swsm_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for the stack core: directed table, then random traffic vs a predictor.
module tb_top;
    import swsm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 26;

    typedef struct packed {
        logic [1:0]               code;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        logic                     last;
    } stack_result_t;

    typedef struct {
        logic [1:0]               req;
        logic signed [DATA_W-1:0] data;
        int                       reps;
        bit                       typed;
        logic [1:0]               code;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               req_type = REQ_PUSH;
    logic signed [DATA_W-1:0] data_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry_value;
    logic [POS_W-1:0]         position;
    logic                     last;

    logic signed [DATA_W-1:0] stack_image [DEPTH];
    int                       depth_used = 0;
    stack_result_t            awaited_results [$];
    plan_row_t                directed_plan [19];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    logic long_hold_pending = 1'b0;

    stack_with_search_and_middle_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_value (entry_value),
        .position    (position),
        .last        (last)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic void predict_request(input logic [1:0] req,
                                            input logic signed [DATA_W-1:0] data,
                                            ref stack_result_t res [$]);
        int p;
        res.delete();
        case (req)
            REQ_PUSH:
            begin
                if (depth_used >= DEPTH)
                    res.push_back('{ST_FULL, '0, '0, 1'b1});
                else
                begin
                    stack_image[depth_used] = data;
                    depth_used++;
                    res.push_back('{ST_OK, '0, '0, 1'b1});
                end
            end
            REQ_POP:
            begin
                if (depth_used == 0)
                    res.push_back('{ST_EMPTY, '0, '0, 1'b1});
                else
                begin
                    depth_used--;
                    res.push_back('{ST_OK, stack_image[depth_used], '0, 1'b1});
                end
            end
            REQ_SEARCH:
            begin
                for (p = 1; p <= depth_used; p++)
                    if (stack_image[depth_used - p] == data)
                        res.push_back('{ST_OK, data, POS_W'(p), 1'b0});
                if (res.size() == 0)
                    res.push_back('{ST_NOTFOUND, '0, '0, 1'b1});
                else
                    res[res.size() - 1].last = 1'b1;
            end
            default:
            begin
                if (depth_used == 0)
                    res.push_back('{ST_EMPTY, '0, '0, 1'b1});
                else
                begin
                    p = depth_used / 2 + 1;
                    res.push_back('{ST_OK, stack_image[depth_used - p], POS_W'(p), 1'b1});
                end
            end
        endcase
    endfunction

    function automatic logic [1:0] pick_request(input bit filling);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < (filling ? 55 : 15))
            return REQ_PUSH;
        if (roll < 70)
            return REQ_POP;
        if (roll < 88)
            return REQ_SEARCH;
        return REQ_MIDDLE;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] keys [4];
        keys = '{32'sd7, -32'sd7, 32'sh7FFF_FFFF, 32'sh8000_0000};
        case ($urandom_range(9))
            6, 7: return $urandom;
            8: return '0;
            9: return '1;
            default: return keys[$urandom_range(3)];
        endcase
    endfunction

    task automatic drive_item(input logic [1:0] req, input logic signed [DATA_W-1:0] data);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        req_type <= req;
        data_value <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic issue(input logic [1:0] req, input logic signed [DATA_W-1:0] data,
                         input bit typed, input logic [1:0] typed_code);
        stack_result_t predicted [$];
        drive_item(req, data);
        predict_request(req, data, predicted);
        if (typed)
            awaited_results.push_back('{typed_code, '0, '0, 1'b1});
        else
            foreach (predicted[k])
                awaited_results.push_back(predicted[k]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    always @(posedge clk)
    begin : drive_out_ready
        if (long_hold_pending)
        begin
            hold_left = HOLD_CYCLES;
            long_hold_pending <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        stack_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d value %0d position %0d last %0b",
                             status, entry_value, position, last);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.code || entry_value !== want.value
                    || position !== want.pos || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.code, want.value, want.pos, want.last,
                                 status, entry_value, position, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int tx_plan [4];
        int rx_plan [4];
        bit filling;
        logic [1:0] req;

        tx_plan = '{0, 45, 0, 17};
        rx_plan = '{0, 0, 45, 17};
        directed_plan = '{
            '{REQ_POP,    32'sd0,           1,  1'b1, ST_EMPTY},
            '{REQ_MIDDLE, -32'sd1,          1,  1'b1, ST_EMPTY},
            '{REQ_SEARCH, 32'sd0,           1,  1'b1, ST_NOTFOUND},
            '{REQ_PUSH,   32'sh8000_0000,   1,  1'b1, ST_OK},
            '{REQ_PUSH,   32'sh7FFF_FFFF,   1,  1'b1, ST_OK},
            '{REQ_PUSH,   32'sd0,           1,  1'b1, ST_OK},
            '{REQ_PUSH,   -32'sd1,          1,  1'b1, ST_OK},
            '{REQ_PUSH,   32'sh7FFF_FFFF,   1,  1'b1, ST_OK},
            '{REQ_SEARCH, 32'sh7FFF_FFFF,   1,  1'b0, ST_OK},
            '{REQ_SEARCH, 32'sh8000_0000,   1,  1'b0, ST_OK},
            '{REQ_SEARCH, 32'sd5,           1,  1'b1, ST_NOTFOUND},
            '{REQ_MIDDLE, 32'sd0,           1,  1'b0, ST_OK},
            '{REQ_POP,    32'sd0,           5,  1'b0, ST_OK},
            '{REQ_POP,    32'sh5555_5555,   1,  1'b1, ST_EMPTY},
            '{REQ_PUSH,   32'sh5A5A_5A5A,   32, 1'b1, ST_OK},
            '{REQ_PUSH,   32'sd1,           1,  1'b1, ST_FULL},
            '{REQ_SEARCH, 32'sh5A5A_5A5A,   1,  1'b0, ST_OK},
            '{REQ_MIDDLE, 32'sd0,           1,  1'b0, ST_OK},
            '{REQ_SEARCH, 32'sh5A5A_5A5B,   1,  1'b1, ST_NOTFOUND}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            for (int n = 0; n < directed_plan[i].reps; n++)
                issue(directed_plan[i].req, directed_plan[i].data,
                      directed_plan[i].typed, directed_plan[i].code);
        drain();

        filling = 1'b0;
        for (int phase = 0; phase < 4; phase++)
        begin
            tx_idle_pct = tx_plan[phase];
            rx_stall_pct = rx_plan[phase];
            if (phase == 2)
                long_hold_pending <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (depth_used >= DEPTH)
                    filling = 1'b0;
                else if (depth_used == 0)
                    filling = 1'b1;
                req = pick_request(filling);
                issue(req, pick_value(), 1'b0, ST_OK);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: stack_with_search_and_middle_core.f
+incdir+rtl
rtl/swsm_pkg.sv
rtl/swsm_mem.sv
rtl/stack_with_search_and_middle_core.sv
rtl/swsm_checker.sv
tb/tb_top.sv
